[rtl/uapq_pkg.sv]
package uapq_pkg;

   // operation codes carried in req_tuser
   localparam logic [1:0] FUNC_INSERT  = 2'd0;
   localparam logic [1:0] FUNC_PEEK    = 2'd1;
   localparam logic [1:0] FUNC_EXTRACT = 2'd2;
   localparam logic [1:0] FUNC_MODIFY  = 2'd3;

   // status codes carried in rsp_tuser
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned OCC_W   = 7;
   localparam int unsigned ENTRY_W = 2 * DATA_W;
   localparam int unsigned REQ_W   = 64;
   localparam int unsigned RSP_W   = 72;

   // one stored entry, value in the low half
   typedef struct packed {
      logic signed [DATA_W-1:0] priority_f;
      logic signed [DATA_W-1:0] value_f;
   } entry_type;

endpackage

[rtl/unsorted_array_priority_queue.sv]
// Max priority queue of up to CAPACITY (value, priority) entries held unsorted in one
// RAM. Each request word carries an operation in req_tuser (insert, peek, extract max,
// modify key) and returns exactly one response word with a status in rsp_tuser. Insert
// appends. Peek, extract and modify read the stored entries one per cycle through the
// single RAM read port; extract then writes the last entry back into the vacated slot,
// and a modify that hits stops the scan early. Equal priorities resolve to the lowest
// index. One request is worked on at a time; the next request is accepted while a
// finished response still waits on rsp_tready. The RAM is not cleared after reset:
// only entries below the count are ever read.
module unsorted_array_priority_queue
   import uapq_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // item_value[31:0], item_priority[63:32]
   input  logic [1:0]       req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // out_value[31:0], out_priority[63:32],
                                         // occupancy[70:64], zero[71]
   output logic [1:0]       rsp_tuser    // status[1:0]
);

   localparam int unsigned AW    = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_WB   = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [1:0]              func_ff, func_in;
   entry_type               item_ff, item_in;
   logic [CNT_W-1:0]        issue_ff, issue_in;
   logic                    rvalid_ff, rvalid_in;
   logic [AW-1:0]           ridx_ff, ridx_in;
   entry_type               best_ff, best_in;
   logic [AW-1:0]           best_idx_ff, best_idx_in;
   entry_type               last_ff, last_in;
   logic [1:0]              res_status_ff, res_status_in;
   entry_type               res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   entry_type               rsp_ent_ff, rsp_ent_in;
   logic [OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   entry_type               wr_data;
   logic                    rd_en;
   logic [ENTRY_W-1:0]      rd_data;
   entry_type               rd_ent;
   logic [CNT_W-1:0]        cnt_m1;
   logic [AW-1:0]           last_idx;
   logic                    at_last;
   logic                    take_new;
   entry_type               best_next;
   logic [AW-1:0]           best_idx_next;
   logic [CNT_W+OCC_W-1:0]  cnt_ext;
   logic                    out_free;

   uapq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   assign rd_ent   = entry_type'(rd_data);
   assign cnt_m1   = cnt_ff - CNT_W'(1);
   assign last_idx = cnt_m1[AW-1:0];
   assign at_last  = (ridx_ff == last_idx);
   assign rd_en    = (state_ff == S_SCAN) && (issue_ff < cnt_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_ext  = (CNT_W + OCC_W)'(cnt_ff);

   // running maximum including the word now on the read port
   assign take_new      = (ridx_ff == '0) || (rd_ent.priority_f > best_ff.priority_f);
   assign best_next     = take_new ? rd_ent : best_ff;
   assign best_idx_next = take_new ? ridx_ff : best_idx_ff;

   assign req_tready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      item_in       = item_ff;
      issue_in      = issue_ff;
      rvalid_in     = rd_en;
      ridx_in       = issue_ff[AW-1:0];
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AW-1:0];
      wr_data       = item_ff;
      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               item_in  = entry_type'(req_tdata);
               issue_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = STATUS_OK;
            res_in        = '0;
            state_in      = S_DONE;
            unique case (func_ff)
               FUNC_INSERT: begin
                  if (cnt_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               FUNC_PEEK, FUNC_EXTRACT: begin
                  if (cnt_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     res_in        = '1;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               FUNC_MODIFY: begin
                  if (cnt_ff == '0) begin
                     res_status_in = STATUS_NOTFOUND;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (rvalid_ff) begin
               if (func_ff == FUNC_MODIFY) begin
                  // first value match takes the new priority
                  if (rd_ent.value_f == item_ff.value_f) begin
                     wr_en    = 1'b1;
                     wr_addr  = ridx_ff;
                     wr_data  = item_ff;
                     state_in = S_DONE;
                  end else if (at_last) begin
                     res_status_in = STATUS_NOTFOUND;
                     state_in      = S_DONE;
                  end
               end else begin
                  best_in     = best_next;
                  best_idx_in = best_idx_next;
                  if (at_last) begin
                     last_in  = rd_ent;
                     res_in   = best_next;
                     state_in = (func_ff == FUNC_EXTRACT) ? S_WB : S_DONE;
                  end
               end
            end
         end
         S_WB: begin
            // last entry fills the hole left by the maximum
            wr_en    = 1'b1;
            wr_addr  = best_idx_ff;
            wr_data  = last_ff;
            cnt_in   = cnt_m1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ent_in    = res_ff;
               rsp_occ_in    = cnt_ext[OCC_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         issue_ff     <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ff     <= issue_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      item_ff       <= item_in;
      ridx_ff       <= ridx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_occ_ff, rsp_ent_ff};

endmodule

[rtl/uapq_ram.sv]
// generic simple dual-port RAM, one write and one registered read port
module uapq_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
